// ----- hdl/tat_pkg.sv -----
`default_nettype none
package tat_pkg;

  localparam int SMALL_ADC_FULL_DEF = 1023;

  localparam int CODE_W = 24;
  localparam int CH_W   = 3;
  localparam int TEMP_W = 16;
  localparam int RES_W  = 20;
  localparam int IDX_W  = 2;

  // front end widths
  localparam int CPOS_W  = CODE_W - 1;
  localparam int SER10_W = 24;
  localparam int NUM_W   = SER10_W + CPOS_W;
  localparam int DIFF_W  = 29;
  localparam int WIDE_W  = 31;

  // logarithm
  localparam int LN_IN_W    = DIFF_W + RES_W;
  localparam int E_W        = 6;
  localparam int M_W        = 32;
  localparam int NSQ        = 28;
  localparam int LN_W       = 30;
  localparam int LOG_STAGES = NSQ + 3;
  localparam longint LN2_Q28 = 64'd186065280;

  // polynomial
  localparam int POLY_STAGES = 8;
  localparam int RND_SH      = 24;
  localparam int PC_W        = 48;
  localparam longint K0 = 64'd7392221389;
  localparam longint K1 = 64'd1269918314;
  localparam longint K2 = 64'd70497694;
  localparam longint K3 = 64'd1608264;

  localparam int FRONT_STAGES = 3;
  localparam int NS = FRONT_STAGES + LOG_STAGES + POLY_STAGES + 1;

  localparam int T_LOW  = -10000;
  localparam int T_HIGH = 30000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SOURCE_MODE = 2'd0,
    REG_SERIES      = 2'd1,
    REG_NOMINAL     = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

// ----- hdl/tat_if.sv -----
`default_nettype none
interface tat_in_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] adc_code;
  logic [2:0]        channel;
  modport source (output valid, adc_code, channel, input ready);
  modport sink   (input valid, adc_code, channel, output ready);
endinterface

interface tat_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_centi;
  logic [2:0]         result_channel;
  logic [1:0]         status;
  modport source (output valid, temp_centi, result_channel, status, input ready);
  modport sink   (input valid, temp_centi, result_channel, status, output ready);
endinterface
`default_nettype wire

// ----- hdl/tat_log.sv -----
`default_nettype none
module tat_log import tat_pkg::*; (
  input  wire logic                  clk,
  input  wire logic [LOG_STAGES-1:0] en,
  input  wire logic [LN_IN_W-1:0]    n,
  output logic      [LN_W-1:0]       ln
);

  logic [E_W-1:0]     e_enc;
  logic [LN_IN_W-1:0] n0_r;
  logic [E_W-1:0]     e0_r;
  logic [M_W-1:0]     m_r [0:NSQ];
  logic [NSQ-1:0]     f_r [0:NSQ];
  logic [E_W-1:0]     e_r [0:NSQ];
  logic [LN_IN_W+M_W-1:0] wide;
  logic [61:0]        prod;
  logic [LN_W-1:0]    ln_r;

  // leading one position
  always_comb begin
    e_enc = '0;
    for (int i = 1; i < LN_IN_W; i++) begin
      if (n[i]) e_enc = E_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n0_r <= n;
      e0_r <= e_enc;
    end
  end

  // normalise to q1.31
  assign wide = ({{(M_W-1){1'b0}}, n0_r} << (M_W - 1)) >> e0_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m_r[0] <= wide[M_W-1:0];
      f_r[0] <= '0;
      e_r[0] <= e0_r;
    end
  end

  // one fraction bit per squaring stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [2*M_W-1:0] sq;
    logic [M_W:0]     q;
    assign sq = {{M_W{1'b0}}, m_r[k]} * {{M_W{1'b0}}, m_r[k]};
    assign q  = sq[2*M_W-1:M_W-1];
    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        m_r[k+1] <= q[M_W] ? q[M_W:1] : q[M_W-1:0];
        f_r[k+1] <= {f_r[k][NSQ-2:0], q[M_W]};
        e_r[k+1] <= e_r[k];
      end
    end
  end

  assign prod = 62'({e_r[NSQ], f_r[NSQ]}) * 62'(LN2_Q28);

  always_ff @(posedge clk) begin
    if (en[LOG_STAGES-1]) ln_r <= prod[61:32];
  end

  assign ln = ln_r;

endmodule
`default_nettype wire

// ----- hdl/tat_poly.sv -----
`default_nettype none
module tat_poly import tat_pkg::*; (
  input  wire logic                   clk,
  input  wire logic [POLY_STAGES-1:0] en,
  input  wire logic [LN_W-1:0]        ln_num,
  input  wire logic [LN_W-1:0]        ln_den,
  output logic      [PC_W-1:0]        pc,
  output logic                        pc_neg
);

  localparam logic [63:0] HALF = 64'd1 << (RND_SH - 1);

  logic signed [LN_W:0] u;
  logic [LN_W-1:0] mu_r [0:4];
  logic            un_r [0:4];

  logic [50:0] pk_r;
  logic [27:0] r2;
  logic signed [29:0] t;
  logic [27:0] mt_r;
  logic        tn_r;
  logic [57:0] pt_r;
  logic        n3_r;
  logic [34:0] r4;
  logic signed [35:0] s;
  logic [34:0] ms_r;
  logic        sn_r;
  logic [63:0] ps_r;
  logic        n5_r;
  logic [39:0] r6;
  logic signed [41:0] tp;
  logic [40:0] mtp_r;
  logic        tpn_r;
  logic [PC_W-1:0] pc_r;
  logic        pcn_r;

  assign u = $signed({1'b0, ln_num}) - $signed({1'b0, ln_den});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mu_r[0] <= u[LN_W] ? LN_W'(-u) : u[LN_W-1:0];
      un_r[0] <= u[LN_W];
    end
  end

  for (genvar k = 1; k < 5; k++) begin : g_u
    always_ff @(posedge clk) begin
      if (en[k]) begin
        mu_r[k] <= mu_r[k-1];
        un_r[k] <= un_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) pk_r <= 51'(K3) * 51'(mu_r[0]);
  end

  // t = k2 - k3*u
  assign r2 = 28'((64'(pk_r) + HALF) >> RND_SH);
  assign t  = un_r[1] ? (30'(K2) + 30'(r2)) : (30'(K2) - 30'(r2));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mt_r <= t[29] ? 28'(-t) : t[27:0];
      tn_r <= t[29];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pt_r <= 58'(mu_r[2]) * 58'(mt_r);
      n3_r <= un_r[2] ^ tn_r;
    end
  end

  // s = u*t - k1
  assign r4 = 35'((64'(pt_r) + HALF) >> RND_SH);
  assign s  = n3_r ? (-36'(K1) - 36'(r4)) : (36'(r4) - 36'(K1));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ms_r <= s[35] ? 35'(-s) : s[34:0];
      sn_r <= s[35];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      ps_r <= 64'(mu_r[4]) * 64'(ms_r);
      n5_r <= un_r[4] ^ sn_r;
    end
  end

  // temperature in q24
  assign r6 = 40'((ps_r + HALF) >> RND_SH);
  assign tp = n5_r ? (42'(K0) - 42'(r6)) : (42'(K0) + 42'(r6));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mtp_r <= tp[41] ? 41'(-tp) : tp[40:0];
      tpn_r <= tp[41];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      pc_r  <= PC_W'(mtp_r) * PC_W'(100);
      pcn_r <= tpn_r;
    end
  end

  assign pc     = pc_r;
  assign pc_neg = pcn_r;

endmodule
`default_nettype wire

// ----- hdl/thermistor_adc_to_temperature_core.sv -----
// throughput: one word per cycle while the output is ready; every stage holds one word, the longest
// stretch being the 28 squaring stages of each logarithm unit
// a stalled output holds back only the stages behind it that are full
// reset (rst_n low, synchronous) empties the pipeline and restores the registers
`default_nettype none
module thermistor_adc_to_temperature_core import tat_pkg::*; #(
  parameter int SMALL_ADC_FULL = SMALL_ADC_FULL_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  tat_in_if.sink                in_chan,
  tat_out_if.source             out_chan,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [RES_W-1:0] cfg_data
);

  localparam logic signed [WIDE_W-1:0] BRIDGE_FULL = WIDE_W'(1) <<< 29;
  localparam logic [PC_W-1:0] HALF = PC_W'(1) << (RND_SH - 1);

  logic               mode_r;
  logic [SER10_W-1:0] ser10_r;
  logic [RES_W-1:0]   nom_r;
  logic [RES_W-1:0]   ser_eff;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  logic [CH_W-1:0] ch_r  [0:NS-1];
  logic            oor_r [0:NS-1];

  logic signed [WIDE_W-1:0] code_x, full_x, diff_x;
  logic [CPOS_W-1:0] cpos_r;
  logic [DIFF_W-1:0] diff0_r, diff1_r;
  logic [NUM_W-1:0]  num1_r, num2_r;
  logic [LN_IN_W-1:0] den2_r;
  logic [LN_W-1:0] ln_num, ln_den;
  logic [PC_W-1:0] pc;
  logic            pc_neg;
  logic [23:0]     rc;
  logic signed [25:0] centi;
  logic signed [TEMP_W-1:0] temp_r;
  status_t         status_r;

  // configuration
  assign ser_eff = (cfg_data == '0) ? RES_W'(1) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      ser10_r <= SER10_W'(100000);
      nom_r   <= RES_W'(10000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_MODE: mode_r  <= cfg_data[0];
        REG_SERIES:      ser10_r <= SER10_W'(ser_eff) * SER10_W'(10);
        REG_NOMINAL:     nom_r   <= ser_eff;
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when it is empty or the next one moves
  assign en[NS] = out_chan.ready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_chan.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_chan.ready = en[0];

  // stage 0: range check
  assign code_x = WIDE_W'(in_chan.adc_code);
  assign full_x = mode_r ? BRIDGE_FULL : WIDE_W'(SMALL_ADC_FULL);
  assign diff_x = full_x - code_x;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ch_r[0]  <= in_chan.channel;
      oor_r[0] <= (code_x <= 0) || (code_x >= full_x);
      cpos_r   <= in_chan.adc_code[CPOS_W-1:0];
      diff0_r  <= diff_x[DIFF_W-1:0];
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        ch_r[k]  <= ch_r[k-1];
        oor_r[k] <= oor_r[k-1];
      end
    end
  end

  // stage 1: numerator, stage 2: denominator
  always_ff @(posedge clk) begin
    if (en[1]) begin
      num1_r  <= NUM_W'(ser10_r) * NUM_W'(cpos_r);
      diff1_r <= diff0_r;
    end
    if (en[2]) begin
      num2_r <= num1_r;
      den2_r <= LN_IN_W'(diff1_r) * LN_IN_W'(nom_r);
    end
  end

  tat_log u_log_num (
    .clk (clk),
    .en  (en[FRONT_STAGES +: LOG_STAGES]),
    .n   (LN_IN_W'(num2_r)),
    .ln  (ln_num)
  );

  tat_log u_log_den (
    .clk (clk),
    .en  (en[FRONT_STAGES +: LOG_STAGES]),
    .n   (den2_r),
    .ln  (ln_den)
  );

  tat_poly u_poly (
    .clk    (clk),
    .en     (en[FRONT_STAGES + LOG_STAGES +: POLY_STAGES]),
    .ln_num (ln_num),
    .ln_den (ln_den),
    .pc     (pc),
    .pc_neg (pc_neg)
  );

  // output stage: round to hundredths and clamp, or flag an out of range input
  assign rc    = 24'((pc + HALF) >> RND_SH);
  assign centi = pc_neg ? -26'(rc) : 26'(rc);

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      if (oor_r[NS-2]) begin
        temp_r   <= '0;
        status_r <= ST_RANGE;
      end else if (centi < 26'(T_LOW)) begin
        temp_r   <= TEMP_W'(T_LOW);
        status_r <= ST_SAT;
      end else if (centi > 26'(T_HIGH)) begin
        temp_r   <= TEMP_W'(T_HIGH);
        status_r <= ST_SAT;
      end else begin
        temp_r   <= centi[TEMP_W-1:0];
        status_r <= ST_OK;
      end
    end
  end

  assign out_chan.valid          = v_r[NS-1];
  assign out_chan.temp_centi     = temp_r;
  assign out_chan.result_channel = ch_r[NS-1];
  assign out_chan.status         = status_r;

endmodule
`default_nettype wire

// ----- bench/tb_thermistor_adc_to_temperature_core.sv -----
`default_nettype none
module tb_thermistor_adc_to_temperature_core;
  import tat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SMALL = SMALL_ADC_FULL_DEF;
  localparam longint FULL_BRIDGE = 64'd1 << 29;
  localparam int LAT = 43;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic [2:0]         result_channel;
    status_t            status;
  } reading_t;

  // behavioural copy of the conversion: resistance ratio, log, cubic
  class temp_scoreboard;
    bit              mode;
    longint unsigned series_ohm;
    longint unsigned nominal_ohm;
    reading_t        pending[$];
    int              n_in, n_out, n_err, n_range, n_sat;

    function new();
      mode = 0;
      series_ohm = 10000;
      nominal_ohm = 10000;
    endfunction

    function longint ln_fixed(longint unsigned n);
      int e;
      longint unsigned m, frac, l;
      e = 0;
      frac = 0;
      if (n == 0) n = 1;
      while (e < 63 && (n >> (e + 1)) != 0) e++;
      if (e > 31) m = n >> (e - 31);
      else m = n << (31 - e);
      for (int i = 0; i < 28; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= (64'd1 << 32)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      l = (longint'(e) << 28) | frac;
      // l*ln2 overflows 64 bits only beyond what the inputs reach
      return longint'((l * LN2_Q28) >> 32);
    endfunction

    function longint mul_rnd(longint a, longint b);
      longint unsigned ma, mb, p;
      bit neg;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = (ma * mb + (64'd1 << 23)) >> 24;
      neg = (a < 0) != (b < 0);
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function void write_reg(reg_idx_t idx, logic [RES_W-1:0] d);
      case (idx)
        REG_SOURCE_MODE: mode = d[0];
        REG_SERIES:      series_ohm = d;
        REG_NOMINAL:     nominal_ohm = d;
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [23:0] code, logic [2:0] ch);
      reading_t r;
      longint c, full, u, t, s, tq, centi;
      longint unsigned ser, nom;
      c = code;
      full = mode ? FULL_BRIDGE : FULL_SMALL;
      ser = series_ohm ? series_ohm : 1;
      nom = nominal_ohm ? nominal_ohm : 1;
      r.result_channel = ch;
      n_in++;
      if (c <= 0 || c >= full) begin
        r.temp_centi = 0;
        r.status = ST_RANGE;
        n_range++;
      end else begin
        u = ln_fixed(ser * 10 * c) - ln_fixed((full - c) * nom);
        t = K2 - mul_rnd(K3, u);
        s = -K1 + mul_rnd(u, t);
        tq = K0 + mul_rnd(u, s);
        centi = mul_rnd(tq, 100);
        r.status = ST_OK;
        if (centi < T_LOW) begin
          centi = T_LOW;
          r.status = ST_SAT;
        end else if (centi > T_HIGH) begin
          centi = T_HIGH;
          r.status = ST_SAT;
        end
        if (r.status == ST_SAT) n_sat++;
        r.temp_centi = centi[15:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(reading_t got);
      reading_t want;
      n_out++;
      if (pending.size() == 0) begin
        $error("unexpected result word: temp %0d ch %0d status %0d",
               got.temp_centi, got.result_channel, got.status);
        n_err++;
        return;
      end
      want = pending.pop_front();
      if (got.temp_centi !== want.temp_centi) begin
        $error("temp_centi: expected %0d, got %0d", want.temp_centi, got.temp_centi);
        n_err++;
      end
      if (got.result_channel !== want.result_channel) begin
        $error("result_channel: expected %0d, got %0d",
               want.result_channel, got.result_channel);
        n_err++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        n_err++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [RES_W-1:0] cfg_data = '0;

  tat_in_if  in_chan();
  tat_out_if out_chan();

  thermistor_adc_to_temperature_core DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  temp_scoreboard sb = new();
  bit stall_enable = 0;
  bit sending_done = 0;
  int quiet_cycles = 0;

  initial begin
    in_chan.valid = 0;
    in_chan.adc_code = '0;
    in_chan.channel = '0;
    out_chan.ready = 0;
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // sink side: ready drops for random stalls while stall_enable is set, checks every accepted word
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result({out_chan.temp_centi, out_chan.result_channel,
                       status_t'(out_chan.status)});
  end

  initial begin
    int n;
    @(posedge clk);
    while (rst_n == 0) @(posedge clk);
    forever begin
      out_chan.ready <= 1;
      n = stall_enable ? $urandom_range(1, 20) : 1;
      repeat (n) @(posedge clk);
      if (stall_enable) begin
        n = gap_len();
        if (n > 0) begin
          out_chan.ready <= 0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("watchdog expired: %0d results still outstanding", sb.pending.size());
      $display("tb_thermistor_adc_to_temperature_core NOT OK");
      $finish;
    end
  end

  task automatic send_reading(logic signed [23:0] code, logic [2:0] ch, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_chan.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.adc_code <= code;
    in_chan.channel <= ch;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_input(code, ch);
  endtask

  task automatic drain();
    in_chan.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [RES_W-1:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, d);
  endtask

  function automatic logic signed [23:0] pick_code(bit m);
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) return 24'($urandom);
    if (k < 12) return 24'($urandom_range(0, 3));
    if (m == 0) begin
      if (k < 20) return 24'(FULL_SMALL - int'($urandom_range(0, 3)));
      return 24'($urandom_range(1, FULL_SMALL - 1));
    end
    if (k < 30) return 24'(24'sh7fffff - $urandom_range(0, 3));
    if (k < 50) return 24'($urandom_range(1, 255) << $urandom_range(0, 15));
    return 24'($urandom_range(1, 24'h7fffff));
  endfunction

  function automatic logic [RES_W-1:0] pick_res();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return 20'hfffff;
    if (k == 2) return RES_W'($urandom_range(1, 10));
    if (k < 6) return RES_W'($urandom_range(1000, 100000));
    return RES_W'($urandom);
  endfunction

  initial begin
    logic signed [23:0] directed[$];
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // divider mode, reset registers: bounds, out of range, channel sweep
    directed = '{0, 1, 2, 511, 512, 1021, 1022, 1023, 1024, -1, 24'sh800000, 24'sh7fffff};
    foreach (directed[i]) send_reading(directed[i], i[2:0], 0);
    drain();
    write_reg(REG_SOURCE_MODE, RES_W'(1));
    directed = '{1, 24'sh7fffff, 24'sh555555, 24'sh2aaaaa, 24'sh100000, 24'sh000fff,
                 0, 24'sh800000, 24'shffffff};
    foreach (directed[i]) send_reading(directed[i], 3'(7 - i), 0);
    drain();
    // extreme resistances, including zero treated as one ohm
    write_reg(REG_SERIES, '0);
    write_reg(REG_NOMINAL, 20'hfffff);
    send_reading(24'sh7fffff, 3'd5, 0);
    send_reading(24'sd1, 3'd2, 0);
    drain();
    write_reg(REG_SERIES, 20'hfffff);
    write_reg(REG_NOMINAL, '0);
    write_reg(REG_SOURCE_MODE, '0);
    send_reading(24'sd1, 3'd1, 0);
    send_reading(24'sd1022, 3'd6, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      stall_enable = (ph % 3) != 0;
      write_reg(REG_SOURCE_MODE, RES_W'(ph % 2));
      if (ph < 2) begin
        write_reg(REG_SERIES, RES_W'(10000));
        write_reg(REG_NOMINAL, RES_W'(10000));
      end else begin
        write_reg(REG_SERIES, pick_res());
        write_reg(REG_NOMINAL, pick_res());
      end
      for (int i = 0; i < 75; i++)
        send_reading(pick_code(sb.mode), 3'($urandom_range(0, 7)),
                     stall_enable && ph != 4);
      drain();
    end
    sending_done = 1;

    $display("%0d readings sent, %0d results checked (%0d out of range, %0d saturated)",
             sb.n_in, sb.n_out, sb.n_range, sb.n_sat);
    $display("both converter modes, extreme and random resistances, random stalls");
    if (sb.n_err == 0 && sb.pending.size() == 0)
      $display("tb_thermistor_adc_to_temperature_core OK");
    else
      $display("tb_thermistor_adc_to_temperature_core NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
